/* hw/rtl/pfs_pkg.sv */
`default_nettype none

package pfs_pkg;

  // Field widths of the channels.
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned FTYPE_W = 5;
  localparam int unsigned FNUM_W  = 29;
  localparam int unsigned RAW_W   = 64;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CAP_W   = 32;
  localparam int unsigned WT_W    = 3;
  localparam int unsigned KEY_W   = FNUM_W + WT_W;
  localparam int unsigned KLEN_W  = 3;
  localparam int unsigned VLEN_W  = 4;

  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // Commands.
  localparam logic [CMD_W-1:0] CMD_START   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FIELD   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PAYLOAD = 2'd2;

  // Field types.
  localparam logic [FTYPE_W-1:0] FT_DOUBLE   = 5'd0;
  localparam logic [FTYPE_W-1:0] FT_FLOAT    = 5'd1;
  localparam logic [FTYPE_W-1:0] FT_INT32    = 5'd2;
  localparam logic [FTYPE_W-1:0] FT_UINT32   = 5'd3;
  localparam logic [FTYPE_W-1:0] FT_SINT32   = 5'd4;
  localparam logic [FTYPE_W-1:0] FT_INT64    = 5'd5;
  localparam logic [FTYPE_W-1:0] FT_UINT64   = 5'd6;
  localparam logic [FTYPE_W-1:0] FT_SINT64   = 5'd7;
  localparam logic [FTYPE_W-1:0] FT_FIXED32  = 5'd8;
  localparam logic [FTYPE_W-1:0] FT_FIXED64  = 5'd9;
  localparam logic [FTYPE_W-1:0] FT_SFIXED32 = 5'd10;
  localparam logic [FTYPE_W-1:0] FT_SFIXED64 = 5'd11;
  localparam logic [FTYPE_W-1:0] FT_BOOL     = 5'd12;
  localparam logic [FTYPE_W-1:0] FT_ENUM     = 5'd13;
  localparam logic [FTYPE_W-1:0] FT_STRING   = 5'd14;
  localparam logic [FTYPE_W-1:0] FT_BYTES    = 5'd15;
  localparam logic [FTYPE_W-1:0] FT_MESSAGE  = 5'd16;

  // Wire types.
  localparam logic [WT_W-1:0] WT_VARNUM = 3'd0;
  localparam logic [WT_W-1:0] WT_I64    = 3'd1;
  localparam logic [WT_W-1:0] WT_LEN    = 3'd2;
  localparam logic [WT_W-1:0] WT_I32    = 3'd5;

  typedef enum logic [1:0] {
    JOB_OVF,
    JOB_BYTE,
    JOB_FIELD
  } job_kind_t;

  // One unit of work handed from the front end to the byte emitter.
  typedef struct packed {
    job_kind_t               kind;
    logic [BYTE_W-1:0]       pbyte;
    logic                    has_key;
    logic [KEY_W-1:0]        key;
    logic [KLEN_W-1:0]       key_len;
    logic [RAW_W-1:0]        val;
    logic                    val_le;
    logic [VLEN_W-1:0]       val_len;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_KEY,
    BK_VAL
  } back_state_t;

  // Number of base-128 groups needed for a value, at least one.
  function automatic logic [VLEN_W-1:0] varint_len(input logic [RAW_W-1:0] v);
    logic [VLEN_W-1:0] len;
    len = VLEN_W'(1);
    for (int i = 1; i < 10; i++) begin
      if ((v >> (7 * i)) != '0) begin
        len = VLEN_W'(i + 1);
      end
    end
    return len;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/pfs_ifs.sv */
`default_nettype none

interface pfs_in_if;
  import pfs_pkg::*;
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [FTYPE_W-1:0]  field_type;
  logic [FNUM_W-1:0]   field_number;
  logic [RAW_W-1:0]    raw_value;
  logic                omit_key;
  logic [BYTE_W-1:0]   payload_byte;

  modport source(output valid, command, field_type, field_number, raw_value, omit_key,
                 payload_byte, input ready);
  modport sink(input valid, command, field_type, field_number, raw_value, omit_key,
               payload_byte, output ready);
endinterface

interface pfs_out_if;
  import pfs_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              byte_valid;
  logic              last;
  logic              status;

  modport source(output valid, out_byte, byte_valid, last, status, input ready);
  modport sink(input valid, out_byte, byte_valid, last, status, output ready);
endinterface

interface pfs_cfg_if;
  import pfs_pkg::*;
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] capacity_bytes;

  modport source(output valid, capacity_bytes, input ready);
  modport sink(input valid, capacity_bytes, output ready);
endinterface

`default_nettype wire

/* hw/rtl/pfs_front.sv */
`default_nettype none

module pfs_front (
  input  wire logic    clk,
  input  wire logic    rst_n,
  pfs_in_if.sink       in_ch,
  pfs_cfg_if.sink      cfg_ch,
  output logic         push_valid,
  input  wire logic    push_ready,
  output pfs_pkg::job_t push_data
);
  import pfs_pkg::*;

  typedef enum logic [1:0] {
    ACT_DROP,
    ACT_START,
    ACT_FIELD,
    ACT_BYTE
  } act_t;

  logic [CAP_W-1:0]   cap_r;
  logic [CAP_W-1:0]   used_r;
  logic [CAP_W-1:0]   used_nxt;

  // Stage 1: captured transaction.
  logic               s1_v_r;
  logic               s1_v_nxt;
  logic [CMD_W-1:0]   s1_cmd_r;
  logic [FTYPE_W-1:0] s1_ftype_r;
  logic [FNUM_W-1:0]  s1_fnum_r;
  logic [RAW_W-1:0]   s1_raw_r;
  logic               s1_omit_r;
  logic [BYTE_W-1:0]  s1_pbyte_r;

  // Stage 2: classified job waiting for the capacity check.
  logic               s2_v_r;
  logic               s2_v_nxt;
  act_t               s2_act_r;
  job_t               s2_job_r;
  logic [VLEN_W-1:0]  s2_n_r;
  logic [CAP_W:0]     s2_extra_r;
  logic               s2_big_r;

  logic [WT_W-1:0]    wt;
  logic [31:0]        lo;
  logic [RAW_W-1:0]   val;
  logic               le;
  logic [VLEN_W-1:0]  vlen;
  logic [KLEN_W-1:0]  klen;
  logic [KEY_W-1:0]   key;
  logic [VLEN_W-1:0]  n;
  logic               lenx;
  logic [CAP_W:0]     extra;
  logic               big;
  act_t               act;
  job_t               job;

  logic               in_acc;
  logic               s2_need;
  logic               s2_done;
  logic               s2_load;
  logic               ovf;

  always_comb begin
    unique case (s1_ftype_r) inside
      FT_DOUBLE, FT_FIXED64, FT_SFIXED64: wt = WT_I64;
      FT_FLOAT, FT_FIXED32, FT_SFIXED32:  wt = WT_I32;
      FT_STRING, FT_BYTES, FT_MESSAGE:    wt = WT_LEN;
      default:                            wt = WT_VARNUM;
    endcase
  end

  always_comb begin
    lo  = s1_raw_r[31:0];
    val = s1_raw_r;
    le  = 1'b0;
    unique case (s1_ftype_r) inside
      FT_INT32, FT_ENUM:                  val = {{32{lo[31]}}, lo};
      FT_UINT32:                          val = {32'b0, lo};
      FT_SINT32:                          val = {32'b0, (lo << 1) ^ {32{lo[31]}}};
      FT_SINT64:                          val = (s1_raw_r << 1) ^ {RAW_W{s1_raw_r[RAW_W-1]}};
      FT_BOOL:                            val = {{(RAW_W-1){1'b0}}, |s1_raw_r};
      FT_FLOAT, FT_FIXED32, FT_SFIXED32: begin
        val = {32'b0, lo};
        le  = 1'b1;
      end
      FT_DOUBLE, FT_FIXED64, FT_SFIXED64: le = 1'b1;
      default:                            val = s1_raw_r;
    endcase

    key  = {s1_fnum_r, wt};
    klen = KLEN_W'(varint_len({{(RAW_W-KEY_W){1'b0}}, key}));
    if (le) begin
      vlen = (wt == WT_I32) ? VLEN_W'(4) : VLEN_W'(8);
    end else begin
      vlen = varint_len(val);
    end
    n = (s1_omit_r ? VLEN_W'(0) : VLEN_W'(klen)) + vlen;

    // Length-delimited fields must also leave room for their payload.
    lenx  = (wt == WT_LEN);
    extra = lenx ? ({1'b0, s1_raw_r[31:0]} + (CAP_W+1)'(n)) : (CAP_W+1)'(n);
    big   = lenx && ((s1_raw_r[63:32] != '0) || (s1_raw_r[31:0] > cap_r));

    unique case (s1_cmd_r)
      CMD_START:   act = ACT_START;
      CMD_FIELD:   act = (s1_ftype_r <= FT_MESSAGE) ? ACT_FIELD : ACT_DROP;
      CMD_PAYLOAD: act = ACT_BYTE;
      default:     act = ACT_DROP;
    endcase

    job.kind    = JOB_FIELD;
    job.pbyte   = s1_pbyte_r;
    job.has_key = !s1_omit_r;
    job.key     = key;
    job.key_len = klen;
    job.val     = val;
    job.val_le  = le;
    job.val_len = vlen;

    if (act == ACT_BYTE) begin
      job.kind = JOB_BYTE;
      n        = VLEN_W'(1);
      extra    = (CAP_W+1)'(1);
      big      = 1'b0;
    end
  end

  // Stage 2 handshake and capacity check.
  always_comb begin
    ovf        = s2_big_r ||
                 (({2'b0, used_r} + {1'b0, s2_extra_r}) > {2'b0, cap_r});
    s2_need    = (s2_act_r == ACT_FIELD) || (s2_act_r == ACT_BYTE);
    push_valid = s2_v_r && s2_need;
    push_data  = s2_job_r;
    if (ovf) begin
      push_data.kind = JOB_OVF;
    end
    s2_done     = s2_v_r && (!s2_need || push_ready);
    s2_load     = s1_v_r && (!s2_v_r || s2_done);
    in_ch.ready = !s1_v_r || s2_load;
    in_acc      = in_ch.valid && in_ch.ready;
    cfg_ch.ready = 1'b1;

    s1_v_nxt = in_acc ? 1'b1 : (s2_load ? 1'b0 : s1_v_r);
    s2_v_nxt = s2_load ? 1'b1 : (s2_done ? 1'b0 : s2_v_r);

    used_nxt = used_r;
    if (s2_done) begin
      if (s2_act_r == ACT_START) begin
        used_nxt = '0;
      end else if (s2_need && !ovf) begin
        used_nxt = used_r + CAP_W'(s2_n_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      used_r <= '0;
      cap_r  <= '1;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
      used_r <= used_nxt;
      if (cfg_ch.valid) begin
        cap_r <= cfg_ch.capacity_bytes;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r   <= in_ch.command;
      s1_ftype_r <= in_ch.field_type;
      s1_fnum_r  <= in_ch.field_number;
      s1_raw_r   <= in_ch.raw_value;
      s1_omit_r  <= in_ch.omit_key;
      s1_pbyte_r <= in_ch.payload_byte;
    end
    if (s2_load) begin
      s2_act_r   <= act;
      s2_job_r   <= job;
      s2_n_r     <= n;
      s2_extra_r <= extra;
      s2_big_r   <= big;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/pfs_queue.sv */
`default_nettype none

module pfs_queue #(
  parameter int unsigned DEPTH = pfs_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push_valid,
  output logic                push_ready,
  input  wire pfs_pkg::job_t  push_data,
  output logic                pop_valid,
  input  wire logic           pop_ready,
  output pfs_pkg::job_t       pop_data
);
  import pfs_pkg::*;

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  job_t            mem_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r;
  logic [PtrW-1:0] rd_ptr_r;
  logic [CntW-1:0] count_r;
  logic [PtrW-1:0] wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_nxt;
  logic [CntW-1:0] count_nxt;
  logic            do_push;
  logic            do_pop;

  always_comb begin
    push_ready = (count_r != CntW'(DEPTH));
    pop_valid  = (count_r != '0);
    pop_data   = mem_r[rd_ptr_r];
    do_push    = push_valid && push_ready;
    do_pop     = pop_valid && pop_ready;

    wr_ptr_nxt = wr_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    rd_ptr_nxt = rd_ptr_r;
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    count_nxt = count_r + CntW'(do_push) - CntW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/pfs_back.sv */
`default_nettype none

module pfs_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          pop_valid,
  output logic               pop_ready,
  input  wire pfs_pkg::job_t pop_data,
  pfs_out_if.source          out_ch
);
  import pfs_pkg::*;

  back_state_t       state_r;
  back_state_t       state_nxt;
  logic [KEY_W-1:0]  key_r;
  logic [RAW_W-1:0]  val_r;
  logic              val_le_r;
  logic [VLEN_W-1:0] val_len_r;
  logic [VLEN_W-1:0] cnt_r;

  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_bv_r;
  logic              out_last_r;
  logic              out_status_r;

  logic              slot_free;
  logic              load;
  logic              emit;
  logic [BYTE_W-1:0] emit_byte;
  logic              emit_bv;
  logic              emit_last;
  logic              emit_status;
  logic              cnt_one;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign cnt_one   = (cnt_r == VLEN_W'(1));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (pop_valid && (pop_data.kind == JOB_FIELD)) begin
          state_nxt = pop_data.has_key ? BK_KEY : BK_VAL;
        end
      end
      BK_KEY: begin
        if (slot_free && cnt_one) begin
          state_nxt = BK_VAL;
        end
      end
      BK_VAL: begin
        if (slot_free && cnt_one) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    pop_ready   = 1'b0;
    load        = 1'b0;
    emit        = 1'b0;
    emit_byte   = '0;
    emit_bv     = 1'b0;
    emit_last   = 1'b0;
    emit_status = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (pop_valid) begin
          unique case (pop_data.kind)
            JOB_FIELD: begin
              pop_ready = 1'b1;
              load      = 1'b1;
            end
            JOB_BYTE: begin
              pop_ready = slot_free;
              emit      = slot_free;
              emit_byte = pop_data.pbyte;
              emit_bv   = 1'b1;
              emit_last = 1'b1;
            end
            default: begin
              pop_ready   = slot_free;
              emit        = slot_free;
              emit_last   = 1'b1;
              emit_status = 1'b1;
            end
          endcase
        end
      end
      BK_KEY: begin
        emit      = slot_free;
        emit_byte = {!cnt_one, key_r[6:0]};
        emit_bv   = 1'b1;
      end
      BK_VAL: begin
        emit      = slot_free;
        emit_byte = val_le_r ? val_r[7:0] : {!cnt_one, val_r[6:0]};
        emit_bv   = 1'b1;
        emit_last = cnt_one;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      key_r     <= pop_data.key;
      val_r     <= pop_data.val;
      val_le_r  <= pop_data.val_le;
      val_len_r <= pop_data.val_len;
      cnt_r     <= pop_data.has_key ? VLEN_W'(pop_data.key_len) : pop_data.val_len;
    end else if (emit && (state_r == BK_KEY)) begin
      key_r <= key_r >> 7;
      cnt_r <= cnt_one ? val_len_r : cnt_r - VLEN_W'(1);
    end else if (emit && (state_r == BK_VAL)) begin
      val_r <= val_le_r ? (val_r >> 8) : (val_r >> 7);
      cnt_r <= cnt_r - VLEN_W'(1);
    end
    if (emit) begin
      out_byte_r   <= emit_byte;
      out_bv_r     <= emit_bv;
      out_last_r   <= emit_last;
      out_status_r <= emit_status;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_byte   = out_byte_r;
  assign out_ch.byte_valid = out_bv_r;
  assign out_ch.last       = out_last_r;
  assign out_ch.status     = out_status_r;

endmodule

`default_nettype wire

/* hw/rtl/protobuf_field_serializer.sv */
// Protocol buffer field serializer.
// The input channel carries one command per transaction: start message (clears the byte
// count), field (type, number, raw value, packed-mode key omission) or payload byte.
// The output channel carries one wire byte per transaction with a last flag on the final
// byte of each input transaction; an overflowing field or byte gives one transaction
// with status set and no byte. Start messages and unknown commands or types give none.
// The configuration channel writes the buffer capacity; it is always ready, and the user must
// write it only while the block is idle; the block itself does not enforce this.
// Timing: a payload byte passes the two front stages, the job queue and the output register;
// a field also passes a load step in the byte emitter before its first byte. The emitter
// produces one byte per cycle while the receiver holds ready high, loading each field
// before its key and value bytes. The emitter sets the throughput.
// A job queue between the front end and the emitter lets the front end keep accepting
// and checking items while the emitter works or the receiver stalls; when the receiver
// holds ready low the output register keeps its transaction and backpressure reaches
// the input once the queue and both front stages are full.
// Reset clears the byte count, sets the capacity to all ones and empties the pipeline.
`default_nettype none

module protobuf_field_serializer #(
  parameter int unsigned QUEUE_DEPTH = pfs_pkg::QUEUE_DEPTH_DEF
) (
  input wire logic   clk,
  input wire logic   rst_n,
  pfs_in_if.sink     in_ch,
  pfs_out_if.source  out_ch,
  pfs_cfg_if.sink    cfg_ch
);
  import pfs_pkg::*;

  // Front end to queue.
  logic q_push_valid;
  logic q_push_ready;
  job_t q_push_data;

  // Queue to byte emitter.
  logic q_pop_valid;
  logic q_pop_ready;
  job_t q_pop_data;

  // Front end: captures transactions, maps the value, sizes the key and value,
  // and checks the byte count against the capacity.
  pfs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_ch     (cfg_ch),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  (q_push_data)
  );

  pfs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  (q_push_data),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_data   (q_pop_data)
  );

  // Back end: turns each job into output transactions, one per cycle while the output is not stalled.
  pfs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (q_pop_valid),
    .pop_ready (q_pop_ready),
    .pop_data  (q_pop_data),
    .out_ch    (out_ch)
  );

  // A job the queue cannot take must stay offered unchanged.
  a_job_held: assert property (@(posedge clk) disable iff (!rst_n)
    q_push_valid && !q_push_ready |=> q_push_valid && $stable(q_push_data))
    else $error("front end dropped or changed a stalled job");

  // An overflow report never carries a byte and always closes its transaction.
  a_ovf_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status |-> !out_ch.byte_valid && out_ch.last)
    else $error("overflow report with a byte or without last");

  // Nothing is offered at the output right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("output valid right after reset");

endmodule

`default_nettype wire
